>>> hw/rtl/keta_pkg.sv
// keyed entry table: shared types, constants and status codes
`timescale 1ns / 1ps

package keta_pkg;

  // table geometry
  localparam int NUM_ENTRIES  = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int IDX_W        = $clog2(NUM_ENTRIES);
  localparam int CNT_W        = $clog2(NUM_ENTRIES + 1);

  // field widths of the request and result
  localparam int KEY_W        = 64;
  localparam int IN_PL_W      = 64;
  localparam int STATUS_W     = 3;
  localparam int OUT_IDX_W    = 6;
  localparam int OUT_PL_W     = 64;

  // active entry count register
  localparam int CFG_W        = 7;
  localparam int LIM_W        = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(64);

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

  // request payload
  typedef struct packed {
    logic               command;
    logic [KEY_W-1:0]   client_id;
    logic [KEY_W-1:0]   server_id;
    logic [IN_PL_W-1:0] entry_payload;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] entry_index;
    logic [OUT_PL_W-1:0]  read_payload;
  } out_res_t;

  // one stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]        client_id;
    logic [KEY_W-1:0]        server_id;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // access from the sequencer to the entry store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_entry;
  } store_req_t;

  // verdict of the shared compare unit
  typedef struct packed {
    logic key_hit;
    logic empty;
  } cmp_res_t;

endpackage

>>> hw/rtl/keta_store.sv
// keyed entry table: entry memory with per-entry valid bits
`timescale 1ns / 1ps

module keta_store import keta_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  output entry_t     rd_entry
);

  entry_t                 mem [NUM_ENTRIES];
  entry_t                 rd_data_r;
  logic [NUM_ENTRIES-1:0] vld_r;
  logic                   rd_vld_r;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_entry;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // valid bits stand in for clearing the memory at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  // a never-written entry reads as all zero
  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

>>> hw/rtl/keta_cmp.sv
// keyed entry table: shared key compare and empty-entry detect unit
`timescale 1ns / 1ps

module keta_cmp import keta_pkg::*; (
  input  entry_t           entry,
  input  logic [KEY_W-1:0] client_id,
  input  logic [KEY_W-1:0] server_id,
  output cmp_res_t         res
);

  // both keys must match as whole vectors
  assign res.key_hit = (entry.client_id == client_id) && (entry.server_id == server_id);

  // empty means keys and payload all zero
  assign res.empty = ~|entry;

endmodule

>>> hw/rtl/keta_ctrl.sv
// keyed entry table: scan sequencer, config register and result register
`timescale 1ns / 1ps

module keta_ctrl import keta_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_req_t          in_req,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  entry_t           rd_entry,
  input  cmp_res_t         cmp_res,
  output store_req_t       store_req,
  output logic [KEY_W-1:0] key_client,
  output logic [KEY_W-1:0] key_server,
  output logic             out_strobe,
  output out_res_t         out_res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t                  state_r,       state_nxt;
  logic [CFG_W-1:0]        active_r,      active_nxt;
  in_req_t                 req_r,         req_nxt;
  logic [CNT_W-1:0]        limit_r,       limit_nxt;
  logic [CNT_W-1:0]        addr_r,        addr_nxt;
  logic                    cmp_vld_r,     cmp_vld_nxt;
  logic [IDX_W-1:0]        cmp_idx_r,     cmp_idx_nxt;
  logic                    hit_found_r,   hit_found_nxt;
  logic [IDX_W-1:0]        hit_idx_r,     hit_idx_nxt;
  logic [PAYLOAD_BITS-1:0] hit_pl_r,      hit_pl_nxt;
  logic                    empty_found_r, empty_found_nxt;
  logic [IDX_W-1:0]        empty_idx_r,   empty_idx_nxt;
  logic                    out_strobe_r,  out_strobe_nxt;
  out_res_t                out_res_r,     out_res_nxt;

  logic [CNT_W-1:0]        lim_cfg;
  logic [CNT_W-1:0]        last_idx;

  // scan limit saturates at the table size
  assign lim_cfg  = (LIM_W'(active_r) > LIM_W'(NUM_ENTRIES)) ? CNT_W'(NUM_ENTRIES)
                                                             : CNT_W'(active_r);
  assign last_idx = limit_r - CNT_W'(1);

  assign busy       = (state_r != S_IDLE);
  assign key_client = req_r.client_id;
  assign key_server = req_r.server_id;
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  // sequencer next-state logic
  always_comb begin
    state_nxt       = state_r;
    active_nxt      = cfg_we ? cfg_wdata : active_r;
    req_nxt         = req_r;
    limit_nxt       = limit_r;
    addr_nxt        = addr_r;
    cmp_vld_nxt     = cmp_vld_r;
    cmp_idx_nxt     = cmp_idx_r;
    hit_found_nxt   = hit_found_r;
    hit_idx_nxt     = hit_idx_r;
    hit_pl_nxt      = hit_pl_r;
    empty_found_nxt = empty_found_r;
    empty_idx_nxt   = empty_idx_r;
    out_strobe_nxt  = 1'b0;
    out_res_nxt     = out_res_r;
    store_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt         = in_req;
          limit_nxt       = lim_cfg;
          addr_nxt        = '0;
          cmp_vld_nxt     = 1'b0;
          hit_found_nxt   = 1'b0;
          empty_found_nxt = 1'b0;
          state_nxt       = (lim_cfg == '0) ? S_COMMIT : S_SCAN;
        end
      end

      S_SCAN: begin
        // issue one entry read per cycle
        if (addr_r < limit_r) begin
          store_req.rd_en   = 1'b1;
          store_req.rd_addr = addr_r[IDX_W-1:0];
          addr_nxt          = addr_r + CNT_W'(1);
          cmp_vld_nxt       = 1'b1;
          cmp_idx_nxt       = addr_r[IDX_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        // judge the entry read in the previous cycle
        if (cmp_vld_r) begin
          if (cmp_res.key_hit && !hit_found_r) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = cmp_idx_r;
            hit_pl_nxt    = rd_entry.payload;
          end
          if (cmp_res.empty && !empty_found_r) begin
            empty_found_nxt = 1'b1;
            empty_idx_nxt   = cmp_idx_r;
          end
          // first key match ends the scan, as does the last active entry
          if (cmp_res.key_hit || (CNT_W'(cmp_idx_r) == last_idx)) begin
            state_nxt = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        out_strobe_nxt           = 1'b1;
        out_res_nxt.entry_index  = '0;
        out_res_nxt.read_payload = '0;
        store_req.wr_entry.client_id = req_r.client_id;
        store_req.wr_entry.server_id = req_r.server_id;
        store_req.wr_entry.payload   = req_r.entry_payload[PAYLOAD_BITS-1:0];
        if (req_r.command == CMD_WRITE) begin
          if (hit_found_r) begin
            store_req.wr_en         = 1'b1;
            store_req.wr_addr       = hit_idx_r;
            out_res_nxt.status      = ST_UPDATED;
            out_res_nxt.entry_index = OUT_IDX_W'(hit_idx_r);
          end else if (empty_found_r) begin
            store_req.wr_en         = 1'b1;
            store_req.wr_addr       = empty_idx_r;
            out_res_nxt.status      = ST_INSERTED;
            out_res_nxt.entry_index = OUT_IDX_W'(empty_idx_r);
          end else begin
            out_res_nxt.status = ST_FULL;
          end
        end else begin
          if (hit_found_r) begin
            out_res_nxt.status       = ST_HIT;
            out_res_nxt.entry_index  = OUT_IDX_W'(hit_idx_r);
            out_res_nxt.read_payload = OUT_PL_W'(hit_pl_r);
          end else begin
            out_res_nxt.status = ST_MISS;
          end
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, config register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= ACTIVE_RESET;
      out_strobe_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      active_r      <= active_nxt;
      out_strobe_r  <= out_strobe_nxt;
      cmp_vld_r     <= cmp_vld_nxt;
      req_r         <= req_nxt;
      limit_r       <= limit_nxt;
      addr_r        <= addr_nxt;
      cmp_idx_r     <= cmp_idx_nxt;
      hit_found_r   <= hit_found_nxt;
      hit_idx_r     <= hit_idx_nxt;
      hit_pl_r      <= hit_pl_nxt;
      empty_found_r <= empty_found_nxt;
      empty_idx_r   <= empty_idx_nxt;
      out_res_r     <= out_res_nxt;
    end
  end

endmodule

>>> hw/rtl/keyed_entry_table_upsert_lookup_top.sv
// keyed entry table: top level joining sequencer, compare unit and entry store
// sequence: with N = min(active_entries, 64), the scan reads entries 0 to N - 1 in order
//   and stops after the first key match (N = 0 skips it); commit then strobes the result
// requests: one at a time; busy falls with the strobe, so the next start
//   may be taken in the strobe cycle; the scan reads one entry per cycle from the store
// reset: synchronous; table reads as empty, active_entries returns to 64, no strobe pending
// the receiver cannot stall: each result has a single strobe cycle, held on out_res until the next
`timescale 1ns / 1ps

module keyed_entry_table_upsert_lookup_top import keta_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_req_t          in_req,
  output logic             out_strobe,
  output out_res_t         out_res,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  store_req_t       store_req;
  entry_t           rd_entry;
  cmp_res_t         cmp_res;
  logic [KEY_W-1:0] key_client;
  logic [KEY_W-1:0] key_server;

  // sequencer
  keta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rd_entry   (rd_entry),
    .cmp_res    (cmp_res),
    .store_req  (store_req),
    .key_client (key_client),
    .key_server (key_server),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  // shared compare unit
  keta_cmp u_cmp (
    .entry     (rd_entry),
    .client_id (key_client),
    .server_id (key_server),
    .res       (cmp_res)
  );

  // entry store
  keta_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (store_req),
    .rd_entry (rd_entry)
  );

endmodule

>>> hw/rtl/keta_chk.sv
// keyed entry table: port-level checker and its bind to the top level
`timescale 1ns / 1ps

module keta_chk import keta_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_strobe,
  input out_res_t         out_res
);

  // a taken request always makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // a result only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a request in progress");

  // results never come in consecutive cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  // status codes stay in range
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_res.status == ST_UPDATED || out_res.status == ST_INSERTED ||
                    out_res.status == ST_FULL || out_res.status == ST_HIT ||
                    out_res.status == ST_MISS))
    else $error("illegal status code");

  // no index and no payload unless an entry was found or written
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_res.status == ST_FULL || out_res.status == ST_MISS)) |->
      (out_res.entry_index == '0 && out_res.read_payload == '0))
    else $error("index or payload set for full or miss");

endmodule

bind keyed_entry_table_upsert_lookup_top keta_chk u_keta_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
